FILE: hw/rtl/tnep_pkg.sv
// Shared types and constants for the threshold network energy/pressure block.
// Holds opcode and FSM enums, request/response beat structs and default sizes.
// No dependencies.
`timescale 1ns / 1ps

package tnep_pkg;

   localparam int DEF_GENES       = 64;
   localparam int DEF_WEIGHT_BITS = 4;

   // Weights summed per group in the first reduction stage
   localparam int LANE = 8;

   localparam int NODE_W     = 6;
   localparam int VALUE_W    = 4;
   localparam int ENERGY_W   = 17;
   localparam int PRESSURE_W = 7;
   localparam int MASK_BITS  = 64;

   localparam int ENERGY_MAX = 65535;
   localparam int ENERGY_MIN = -65536;

   typedef enum logic [2:0] {
      OP_WR_WEIGHT = 3'd0,
      OP_WR_STATE  = 3'd1,
      OP_CLAMP     = 3'd2,
      OP_UNCLAMP   = 3'd3,
      OP_EVAL      = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [2:0]               opcode;
      logic [NODE_W-1:0]        target_node;
      logic [NODE_W-1:0]        source_node;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [ENERGY_W-1:0] energy;
      logic [PRESSURE_W-1:0]      pressure;
      logic [MASK_BITS-1:0]       unstable_mask;
   } rsp_type;

endpackage

FILE: hw/rtl/tnep_row_sum.sv
// Two-stage reduction of one weight row: lane group sums, then a tree over groups.
// Produces the spin-weighted row sum and the forced-state drive sum.
// Depends on tnep_pkg.
`timescale 1ns / 1ps

module tnep_row_sum #(
   parameter int GENES       = tnep_pkg::DEF_GENES,
   parameter int WEIGHT_BITS = tnep_pkg::DEF_WEIGHT_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_vld,
   input  logic [$clog2(GENES)-1:0]             in_row,
   input  logic [GENES*WEIGHT_BITS-1:0]         row_data,
   input  logic [GENES-1:0]                     spin,
   input  logic [GENES-1:0]                     forced,
   output logic                                 out_vld,
   output logic [$clog2(GENES)-1:0]             out_row,
   output logic signed [WEIGHT_BITS+$clog2(GENES)+1:0] row_e,
   output logic signed [WEIGHT_BITS+$clog2(GENES)+1:0] row_d
);
   import tnep_pkg::*;

   localparam int ROW_W  = $clog2(GENES);
   localparam int GROUPS = (GENES + LANE - 1) / LANE;
   localparam int PAD_N  = GROUPS * LANE;
   localparam int GS_W   = WEIGHT_BITS + 4;
   localparam int RS_W   = WEIGHT_BITS + ROW_W + 2;

   logic [PAD_N*WEIGHT_BITS-1:0] row_pad;
   logic [PAD_N-1:0]             spin_pad;
   logic [PAD_N-1:0]             forced_pad;

   logic signed [GS_W-1:0] grp_e_in [GROUPS];
   logic signed [GS_W-1:0] grp_d_in [GROUPS];
   logic signed [GS_W-1:0] grp_e_ff [GROUPS];
   logic signed [GS_W-1:0] grp_d_ff [GROUPS];
   logic                   grp_vld_ff;
   logic [ROW_W-1:0]       grp_row_ff;

   logic signed [RS_W-1:0] row_e_in;
   logic signed [RS_W-1:0] row_d_in;
   logic signed [RS_W-1:0] row_e_ff;
   logic signed [RS_W-1:0] row_d_ff;
   logic                   out_vld_ff;
   logic [ROW_W-1:0]       out_row_ff;

   // padding lanes carry zero weight
   assign row_pad    = (PAD_N*WEIGHT_BITS)'(row_data);
   assign spin_pad   = PAD_N'(spin);
   assign forced_pad = PAD_N'(forced);

   always_comb begin
      logic signed [WEIGHT_BITS-1:0] w;
      logic signed [GS_W-1:0]        se;
      logic signed [GS_W-1:0]        sd;
      for (int g = 0; g < GROUPS; g++) begin
         se = '0;
         sd = '0;
         for (int k = 0; k < LANE; k++) begin
            w = signed'(row_pad[(g*LANE+k)*WEIGHT_BITS +: WEIGHT_BITS]);
            if (spin_pad[g*LANE+k]) begin
               se = se + GS_W'(w);
            end else begin
               se = se - GS_W'(w);
            end
            if (forced_pad[g*LANE+k]) begin
               sd = sd + GS_W'(w);
            end
         end
         grp_e_in[g] = se;
         grp_d_in[g] = sd;
      end
   end

   always_ff @(posedge clock) begin
      for (int g = 0; g < GROUPS; g++) begin
         grp_e_ff[g] <= grp_e_in[g];
         grp_d_ff[g] <= grp_d_in[g];
      end
      grp_row_ff <= in_row;
      if (reset) begin
         grp_vld_ff <= 1'b0;
      end else begin
         grp_vld_ff <= in_vld;
      end
   end

   always_comb begin
      row_e_in = '0;
      row_d_in = '0;
      for (int g = 0; g < GROUPS; g++) begin
         row_e_in = row_e_in + RS_W'(grp_e_ff[g]);
         row_d_in = row_d_in + RS_W'(grp_d_ff[g]);
      end
   end

   always_ff @(posedge clock) begin
      row_e_ff   <= row_e_in;
      row_d_ff   <= row_d_in;
      out_row_ff <= grp_row_ff;
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= grp_vld_ff;
      end
   end

   assign out_vld = out_vld_ff;
   assign out_row = out_row_ff;
   assign row_e   = row_e_ff;
   assign row_d   = row_d_ff;

endmodule

FILE: hw/rtl/threshold_network_energy_pressure.sv
// Channel   | Ports                      | Handshake
// ----------+----------------------------+-------------------------------------
// request   | start, busy, req_data      | beat taken when start && !busy
// response  | rsp_valid, rsp_data        | one-cycle strobe, no backpressure
//
// Load beats (weight, state, clamp, unclamp) are applied at the accepting edge; busy stays low.
// Evaluate streams one weight row per cycle from the row memory through its single read
// port; the strobe follows the row reads, two reduction stages, the accumulate and the
// result register. busy is high from the cycle after an evaluate is taken through
// the cycle before the strobe; no new beat is taken while busy is high.
// Synchronous active-high reset clears state bits and clamps; weights are
// undefined until written. The receiver cannot stall results.
`timescale 1ns / 1ps

module threshold_network_energy_pressure #(
   parameter int GENES       = tnep_pkg::DEF_GENES,
   parameter int WEIGHT_BITS = tnep_pkg::DEF_WEIGHT_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  tnep_pkg::req_type req_data,
   output logic              rsp_valid,
   output tnep_pkg::rsp_type rsp_data
);
   import tnep_pkg::*;

   localparam int ROW_W  = $clog2(GENES);
   localparam int EXT_W  = ((ROW_W > NODE_W) ? ROW_W : NODE_W) + 1;
   localparam int RS_W   = WEIGHT_BITS + ROW_W + 2;
   localparam int ACC_W  = WEIGHT_BITS + 2*ROW_W + 2;
   localparam int NEG_W  = ((ACC_W > ENERGY_W) ? ACC_W : ENERGY_W) + 1;
   localparam logic signed [NEG_W-1:0] SAT_HI = NEG_W'(ENERGY_MAX);
   localparam logic signed [NEG_W-1:0] SAT_LO = NEG_W'(ENERGY_MIN);

   // weight rows: one row per regulated node
   logic [GENES*WEIGHT_BITS-1:0] wmem [GENES];
   logic [GENES*WEIGHT_BITS-1:0] row_q_ff;

   state_type state_ff, state_in;

   logic [GENES-1:0] node_bits_ff, node_bits_in;
   logic [GENES-1:0] clamp_mask_ff, clamp_mask_in;
   logic [GENES-1:0] clamp_val_ff, clamp_val_in;
   logic [GENES-1:0] forced;

   logic             accept;
   logic             tgt_ok;
   logic             src_ok;
   logic [ROW_W-1:0] tgt_idx;
   logic [ROW_W-1:0] src_idx;
   logic             wr_en;
   logic signed [WEIGHT_BITS-1:0] wr_data;

   logic             rd_en;
   logic [ROW_W-1:0] rd_row_ff, rd_row_in;
   logic             rd_vld_ff;
   logic [ROW_W-1:0] rd_tag_ff;

   logic                   rs_vld;
   logic [ROW_W-1:0]       rs_row;
   logic signed [RS_W-1:0] rs_e;
   logic signed [RS_W-1:0] rs_d;

   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic [MASK_BITS-1:0]    mask_ff, mask_in;
   logic [PRESSURE_W-1:0]   count_ff, count_in;
   logic [EXT_W-1:0]        rs_ext;
   logic                    flag;
   logic signed [ACC_W-1:0] contrib;

   logic signed [NEG_W-1:0] neg_e;
   logic signed [NEG_W-1:0] sat_e;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff;

   assign accept  = start && !busy;
   assign tgt_ok  = EXT_W'(req_data.target_node) < EXT_W'(GENES);
   assign src_ok  = EXT_W'(req_data.source_node) < EXT_W'(GENES);
   assign tgt_idx = ROW_W'(req_data.target_node);
   assign src_idx = ROW_W'(req_data.source_node);
   assign wr_en   = accept && (req_data.opcode == OP_WR_WEIGHT) && tgt_ok && src_ok;
   assign wr_data = WEIGHT_BITS'(req_data.value);

   assign forced = (clamp_mask_ff & clamp_val_ff) | (~clamp_mask_ff & node_bits_ff);

   // ---- FSM ----
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rd_en        = 1'b0;
      rd_row_in    = rd_row_ff;
      rsp_valid_in = 1'b0;
      busy         = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy      = 1'b0;
            rd_row_in = '0;
            if (accept && (req_data.opcode == OP_EVAL)) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            rd_en     = 1'b1;
            rd_row_in = rd_row_ff + 1'b1;
            if (rd_row_ff == ROW_W'(GENES - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (rs_vld && (rs_row == ROW_W'(GENES - 1))) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---- state bits and clamps ----
   always_comb begin
      node_bits_in  = node_bits_ff;
      clamp_mask_in = clamp_mask_ff;
      clamp_val_in  = clamp_val_ff;
      if (accept) begin
         case (req_data.opcode)
            OP_WR_STATE: begin
               if (tgt_ok) begin
                  node_bits_in[tgt_idx] = req_data.value[0];
               end
            end
            OP_CLAMP: begin
               if (tgt_ok) begin
                  clamp_mask_in[tgt_idx] = 1'b1;
                  clamp_val_in[tgt_idx]  = req_data.value[0];
               end
            end
            OP_UNCLAMP: begin
               clamp_mask_in = '0;
               clamp_val_in  = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_bits_ff  <= '0;
         clamp_mask_ff <= '0;
         clamp_val_ff  <= '0;
      end else begin
         node_bits_ff  <= node_bits_in;
         clamp_mask_ff <= clamp_mask_in;
         clamp_val_ff  <= clamp_val_in;
      end
   end

   // ---- weight memory: element write, row read; busy interlocks writes vs. scan ----
   always_ff @(posedge clock) begin
      if (wr_en) begin
         wmem[tgt_idx][src_idx*WEIGHT_BITS +: WEIGHT_BITS] <= wr_data;
      end
      if (rd_en) begin
         row_q_ff <= wmem[rd_row_ff];
      end
   end

   always_ff @(posedge clock) begin
      rd_row_ff <= rd_row_in;
      rd_tag_ff <= rd_row_ff;
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= rd_en;
      end
   end

   tnep_row_sum #(
      .GENES       (GENES),
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_row_sum (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (rd_vld_ff),
      .in_row   (rd_tag_ff),
      .row_data (row_q_ff),
      .spin     (node_bits_ff),
      .forced   (forced),
      .out_vld  (rs_vld),
      .out_row  (rs_row),
      .row_e    (rs_e),
      .row_d    (rs_d)
   );

   // ---- accumulate energy and unstable mask ----
   assign rs_ext  = EXT_W'(rs_row);
   assign contrib = node_bits_ff[rs_row] ? ACC_W'(rs_e) : -ACC_W'(rs_e);
   assign flag    = (rs_ext < EXT_W'(MASK_BITS)) && !clamp_mask_ff[rs_row] &&
                    (((rs_d > 0) && !node_bits_ff[rs_row]) ||
                     ((rs_d < 0) && node_bits_ff[rs_row]));

   always_comb begin
      acc_in   = acc_ff;
      mask_in  = mask_ff;
      count_in = count_ff;
      if (accept) begin
         acc_in   = '0;
         mask_in  = '0;
         count_in = '0;
      end else if (rs_vld) begin
         acc_in = acc_ff + contrib;
         if (flag) begin
            mask_in[rs_ext[NODE_W-1:0]] = 1'b1;
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      mask_ff  <= mask_in;
      count_ff <= count_in;
   end

   // ---- result ----
   assign neg_e = -NEG_W'(acc_ff);

   always_comb begin
      sat_e = neg_e;
      if (neg_e > SAT_HI) begin
         sat_e = SAT_HI;
      end else if (neg_e < SAT_LO) begin
         sat_e = SAT_LO;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_FINISH) begin
         rsp_ff.energy        <= ENERGY_W'(sat_e);
         rsp_ff.pressure      <= count_ff;
         rsp_ff.unstable_mask <= mask_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ---- assertions ----
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   a_pressure_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.pressure == PRESSURE_W'($countones(rsp_data.unstable_mask))))
      else $error("pressure does not match unstable mask");

   a_clamped_excluded: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.unstable_mask & MASK_BITS'(clamp_mask_ff)) == '0))
      else $error("clamped node flagged unstable");

   a_eval_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_data.opcode == OP_EVAL)) |=> busy)
      else $error("evaluate accepted without going busy");

endmodule

FILE: tb/tb_threshold_network_energy_pressure.sv
// Self-checking bench for threshold_network_energy_pressure: weight/state/clamp loads,
// evaluate beats scored against an in-bench network model. Depends on tnep_pkg and the RTL.
`timescale 1ns / 1ps

module tb_threshold_network_energy_pressure;
   import tnep_pkg::*;

   localparam int GENES        = DEF_GENES;
   localparam int RANDOM_BEATS = 1050;
   localparam int DRAIN_CYCLES = GENES + 16;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int REPORT_MAX   = 40;
   localparam int REQ_W        = $bits(req_type);

   // opcodes the block must ignore
   localparam logic [2:0] OP_RSVD_LO = 3'd5;
   localparam logic [2:0] OP_RSVD_HI = 3'd7;

   typedef struct {
      req_type beat;
      int      gap_pct;
   } stim_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    start     = 1'b0;
   req_type req_data  = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_data;

   threshold_network_energy_pressure u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // network copy kept by the bench
   logic signed [DEF_WEIGHT_BITS-1:0] link_w [GENES][GENES];
   logic [GENES-1:0] spin_bits = '0;
   logic [GENES-1:0] clamp_en  = '0;
   logic [GENES-1:0] clamp_val = '0;

   stim_type beats_waiting[$];
   rsp_type  scores_due[$];
   rsp_type  want;
   bit       beat_taken = 1'b0;
   int       gap_pct = 0;
   int       cycle_count = 0;
   int       beats_accepted = 0;
   int       evals_issued = 0;
   int       results_checked = 0;
   int       errors = 0;
   int       pressure_lo = MASK_BITS;
   int       pressure_hi = 0;

   function automatic rsp_type score_network();
      rsp_type          r;
      logic [GENES-1:0] forced_bits;
      int               total;
      int               drive;
      int               si;
      int               sj;
      int               unstable;
      r = '0;
      total = 0;
      unstable = 0;
      forced_bits = (spin_bits & ~clamp_en) | (clamp_val & clamp_en);
      for (int i = 0; i < GENES; i++) begin
         si = spin_bits[i] ? 1 : -1;
         drive = 0;
         for (int j = 0; j < GENES; j++) begin
            sj = spin_bits[j] ? 1 : -1;
            total += int'(link_w[i][j]) * si * sj;
            if (forced_bits[j])
               drive += int'(link_w[i][j]);
         end
         // zero drive never flags a node
         if (i < MASK_BITS && !clamp_en[i] &&
             ((drive > 0 && !spin_bits[i]) || (drive < 0 && spin_bits[i]))) begin
            r.unstable_mask[i] = 1'b1;
            unstable++;
         end
      end
      total = -total;
      if (total > ENERGY_MAX)
         total = ENERGY_MAX;
      if (total < ENERGY_MIN)
         total = ENERGY_MIN;
      r.energy   = total[ENERGY_W-1:0];
      r.pressure = unstable[PRESSURE_W-1:0];
      return r;
   endfunction

   function automatic void apply_beat(req_type b);
      case (b.opcode)
         OP_WR_WEIGHT: link_w[b.target_node][b.source_node] = b.value;
         OP_WR_STATE:  spin_bits[b.target_node] = b.value[0];
         OP_CLAMP: begin
            clamp_en[b.target_node]  = 1'b1;
            clamp_val[b.target_node] = b.value[0];
         end
         OP_UNCLAMP: begin
            clamp_en  = '0;
            clamp_val = '0;
         end
         OP_EVAL: begin
            scores_due = {scores_due, score_network()};
            evals_issued++;
         end
         default: ;
      endcase
   endfunction

   function automatic logic signed [VALUE_W-1:0] low_bit_value(logic b);
      logic signed [VALUE_W-1:0] v;
      v = VALUE_W'($urandom);
      v[0] = b;
      return v;
   endfunction

   task automatic enqueue_beat(input logic [2:0] op, input logic [NODE_W-1:0] tgt,
                               input logic [NODE_W-1:0] src,
                               input logic signed [VALUE_W-1:0] val);
      stim_type s;
      s.beat.opcode      = op;
      s.beat.target_node = tgt;
      s.beat.source_node = src;
      s.beat.value       = val;
      s.gap_pct          = gap_pct;
      beats_waiting = {beats_waiting, s};
   endtask

   task automatic enqueue_eval();
      enqueue_beat(OP_EVAL, NODE_W'($urandom), NODE_W'($urandom), VALUE_W'($urandom));
   endtask

   // write every link; scatter picks random weights, a quarter of them zero
   task automatic fill_links(input logic signed [VALUE_W-1:0] w, input bit scatter);
      logic signed [VALUE_W-1:0] v;
      for (int i = 0; i < GENES; i++) begin
         for (int j = 0; j < GENES; j++) begin
            v = w;
            if (scatter)
               v = ($urandom_range(3) == 0) ? '0 : VALUE_W'($urandom);
            enqueue_beat(OP_WR_WEIGHT, NODE_W'(i), NODE_W'(j), v);
         end
      end
   endtask

   // driver: hold a presented beat until taken, else maybe idle
   always @(negedge clock) begin
      if (beat_taken)
         void'(beats_waiting.pop_front());
      if (reset) begin
         start <= 1'b0;
      end else if (start && !beat_taken) begin
         start <= 1'b1;
      end else if (beats_waiting.size() != 0 &&
                   $urandom_range(99) >= beats_waiting[0].gap_pct) begin
         start    <= 1'b1;
         req_data <= beats_waiting[0].beat;
      end else begin
         start    <= 1'b0;
         req_data <= req_type'(REQ_W'($urandom));
      end
   end

   // monitor: score results, then fold accepted beats into the model
   always @(posedge clock) begin
      cycle_count++;
      beat_taken = !reset && start && !busy;
      if (!reset && rsp_valid) begin
         if (scores_due.size() == 0) begin
            errors++;
            if (errors <= REPORT_MAX)
               $display("%0t: unexpected result, expected none, got energy %0d pressure %0d mask %h",
                        $time, rsp_data.energy, rsp_data.pressure, rsp_data.unstable_mask);
         end else begin
            want = scores_due.pop_front();
            results_checked++;
            if (rsp_data.pressure < pressure_lo)
               pressure_lo = rsp_data.pressure;
            if (rsp_data.pressure > pressure_hi)
               pressure_hi = rsp_data.pressure;
            if (rsp_data.energy !== want.energy) begin
               errors++;
               if (errors <= REPORT_MAX)
                  $display("%0t: energy mismatch, expected %0d, got %0d",
                           $time, want.energy, rsp_data.energy);
            end
            if (rsp_data.pressure !== want.pressure) begin
               errors++;
               if (errors <= REPORT_MAX)
                  $display("%0t: pressure mismatch, expected %0d, got %0d",
                           $time, want.pressure, rsp_data.pressure);
            end
            if (rsp_data.unstable_mask !== want.unstable_mask) begin
               errors++;
               if (errors <= REPORT_MAX)
                  $display("%0t: unstable_mask mismatch, expected %h, got %h",
                           $time, want.unstable_mask, rsp_data.unstable_mask);
            end
         end
      end
      if (beat_taken) begin
         beats_accepted++;
         apply_beat(req_data);
      end
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("threshold_network_energy_pressure regression: fail");
         $finish;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
   end

   initial begin
      int pick;

      // all links at the most negative weight: energy at its top, zero drive
      fill_links(-4'sd8, 1'b0);
      enqueue_eval();
      // every node on: every node pushed to flip
      for (int k = 0; k < GENES; k++)
         enqueue_beat(OP_WR_STATE, NODE_W'(k), NODE_W'($urandom), low_bit_value(1'b1));
      enqueue_eval();

      // clamped nodes drop out of the mask; reclamp replaces the forced bit
      enqueue_beat(OP_CLAMP, '0, NODE_W'($urandom), 4'sd7);
      enqueue_beat(OP_CLAMP, '1, NODE_W'($urandom), -4'sd8);
      enqueue_eval();
      enqueue_beat(OP_CLAMP, '1, '0, 4'sd1);
      enqueue_eval();
      enqueue_beat(OP_WR_WEIGHT, '1, '0, 4'sd7);
      enqueue_beat(OP_WR_WEIGHT, '0, '1, -4'sd1);
      enqueue_beat(OP_WR_WEIGHT, NODE_W'(31), NODE_W'(32), 4'sd0);
      enqueue_beat(OP_WR_WEIGHT, '1, '1, 4'sd7);
      enqueue_beat(OP_WR_STATE, '1, '1, -4'sd2);
      // ignored opcodes with every field bit high
      for (logic [3:0] op = OP_RSVD_LO; op <= OP_RSVD_HI; op++)
         enqueue_beat(op[2:0], '1, '1, -4'sd1);
      enqueue_eval();
      enqueue_beat(OP_UNCLAMP, NODE_W'($urandom), NODE_W'($urandom), VALUE_W'($urandom));
      enqueue_eval();

      for (int k = 0; k < RANDOM_BEATS; k++) begin
         case ((4 * k) / RANDOM_BEATS)
            0:       gap_pct = 0;
            1:       gap_pct = 45;
            2:       gap_pct = 0;
            default: gap_pct = 34;
         endcase
         pick = $urandom_range(99);
         if (pick < 35)
            enqueue_beat(OP_WR_WEIGHT, NODE_W'($urandom), NODE_W'($urandom),
                         ($urandom_range(3) == 0) ? '0 : VALUE_W'($urandom));
         else if (pick < 60)
            enqueue_beat(OP_WR_STATE, NODE_W'($urandom), NODE_W'($urandom),
                         VALUE_W'($urandom));
         else if (pick < 70)
            enqueue_beat(OP_CLAMP, NODE_W'($urandom), NODE_W'($urandom), VALUE_W'($urandom));
         else if (pick < 74)
            enqueue_beat(OP_UNCLAMP, NODE_W'($urandom), NODE_W'($urandom),
                         VALUE_W'($urandom));
         else if (pick < 90)
            enqueue_eval();
         else
            enqueue_beat(3'($urandom_range(OP_RSVD_LO, OP_RSVD_HI)), NODE_W'($urandom),
                         NODE_W'($urandom), VALUE_W'($urandom));
      end
      enqueue_eval();

      while (beats_waiting.size() != 0 || scores_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d beats (%0d evaluates, one full link fill at the lowest weight)",
               beats_accepted, evals_issued);
      $display("checked %0d results, pressure seen from %0d to %0d, %0d mismatches",
               results_checked, pressure_lo, pressure_hi, errors);
      if (errors == 0)
         $display("threshold_network_energy_pressure regression: pass");
      else
         $display("threshold_network_energy_pressure regression: fail");
      $finish;
   end

endmodule
